/* hdl/chts_pkg.sv */
// ----------------------------------------------------------------------------
// chts_pkg: shared types for the sorted chained hash table
// Key width, request kinds and the walk state.
// ----------------------------------------------------------------------------
package chts_pkg;

	localparam int KEY_W = 31;

	typedef enum logic {
		REQ_INSERT = 1'b0,
		REQ_SEARCH = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_READ,
		ST_CHECK,
		ST_LINK,
		ST_DONE
	} walk_state_t;

endpackage

/* hdl/chts_ram.sv */
// ----------------------------------------------------------------------------
// chts_ram: generic simple dual-port RAM
// One write port and one read port, with registered read data.
// ----------------------------------------------------------------------------
module chts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/chts_front.sv */
// ----------------------------------------------------------------------------
// chts_front: request intake and bucket hashing
// Accepts requests, computes key modulo the bucket count by a reciprocal
// multiplication and holds the classified request in a two-entry queue
// for the back end.
// ----------------------------------------------------------------------------
module chts_front import chts_pkg::*; #(
	parameter int BUCKETS = 10
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       in_kind,
	input  logic [KEY_W-1:0]           in_key,
	output logic                       q_valid,
	input  logic                       q_ready,
	output logic                       q_kind,
	output logic [KEY_W-1:0]           q_key,
	output logic [$clog2(BUCKETS)-1:0] q_bucket
);

	localparam int BW = $clog2(BUCKETS);
	localparam int PW = 2 * KEY_W + 1;
	// ceil(2^(KEY_W+BW) / BUCKETS) fits in KEY_W+1 bits and gives the exact
	// quotient for every key after the product is shifted down by KEY_W+BW.
	localparam longint unsigned MAGIC =
		((64'd1 << (KEY_W + BW)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
	localparam logic [KEY_W:0] MAGIC_V = (KEY_W + 1)'(MAGIC);

	// Quotient while phase_q is low, remainder and push once phase_q is high and the queue has room.
	logic             busy_q;
	logic             phase_q;
	logic [KEY_W-1:0] key_q;
	logic             kind_q;
	logic [KEY_W-1:0] quo_q;
	logic [PW-1:0]    prod;
	logic [PW-1:0]    prod_sh;
	logic [KEY_W-1:0] rem;

	// Two-entry queue.
	logic             v_q [2];
	logic             k_q [2];
	logic [KEY_W-1:0] ky_q [2];
	logic [BW-1:0]    b_q [2];
	logic             wptr_q;
	logic             rptr_q;
	logic             push;
	logic             pop;
	logic             full;

	assign full = v_q[0] && v_q[1];
	assign in_ready = !busy_q;
	assign prod = {{(PW - KEY_W){1'b0}}, key_q} * {{(PW - KEY_W - 1){1'b0}}, MAGIC_V};
	assign prod_sh = prod >> (KEY_W + BW);
	assign rem = key_q - quo_q * KEY_W'(BUCKETS);
	assign push = busy_q && phase_q && !full;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= 1'b0;
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			v_q[0] <= 1'b0;
			v_q[1] <= 1'b0;
		end else begin
			if (!busy_q && in_valid) begin
				busy_q <= 1'b1;
				phase_q <= 1'b0;
			end else if (busy_q && !phase_q) begin
				phase_q <= 1'b1;
			end else if (push) begin
				busy_q <= 1'b0;
			end
			if (push) begin
				v_q[wptr_q] <= 1'b1;
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				v_q[rptr_q] <= 1'b0;
				rptr_q <= !rptr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			key_q <= in_key;
			kind_q <= in_kind;
		end
		if (busy_q && !phase_q) begin
			quo_q <= prod_sh[KEY_W-1:0];
		end
		if (push) begin
			k_q[wptr_q] <= kind_q;
			ky_q[wptr_q] <= key_q;
			b_q[wptr_q] <= rem[BW-1:0];
		end
	end

	assign q_valid = v_q[rptr_q];
	assign q_kind = k_q[rptr_q];
	assign q_key = ky_q[rptr_q];
	assign q_bucket = b_q[rptr_q];

endmodule

/* hdl/chts_back.sv */
// ----------------------------------------------------------------------------
// chts_back: chain walker
// Walks a bucket chain one node per pass through ST_READ and ST_CHECK, answers
// searches and links new nodes in ascending order; holds the result in an output register.
// ----------------------------------------------------------------------------
module chts_back import chts_pkg::*; #(
	parameter int BUCKETS = 10,
	parameter int POOL_NODES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_ready,
	input  logic                       q_kind,
	input  logic [KEY_W-1:0]           q_key,
	input  logic [$clog2(BUCKETS)-1:0] q_bucket,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       out_found,
	output logic [KEY_W-1:0]           out_key,
	output logic                       out_status
);

	localparam int BW = $clog2(BUCKETS);
	localparam int AW = $clog2(POOL_NODES);
	localparam int NW = $clog2(POOL_NODES + 1);
	localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

	walk_state_t state_q, state_d;

	logic [NW-1:0]    heads_q [BUCKETS];
	logic [NW-1:0]    used_q;
	logic [NW-1:0]    cur_q;
	logic [NW-1:0]    prev_q;
	logic [NW-1:0]    steps_q;
	logic             kind_q;
	logic [KEY_W-1:0] key_q;
	logic [BW-1:0]    bucket_q;
	logic             found_q;
	logic             status_q;
	logic             ovalid_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [KEY_W-1:0] kwdata;
	logic [NW-1:0]    lwdata;
	logic             kwe;
	logic [AW-1:0]    raddr;
	logic [KEY_W-1:0] krd;
	logic [NW-1:0]    lrd;

	chts_ram #(.WIDTH(KEY_W), .DEPTH(POOL_NODES)) u_keys (
		.clk(clk), .we(kwe), .waddr(waddr), .wdata(kwdata), .raddr(raddr), .rdata(krd)
	);
	chts_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_links (
		.clk(clk), .we(we), .waddr(waddr), .wdata(lwdata), .raddr(raddr), .rdata(lrd)
	);

	logic walk_end;
	logic hit;
	logic done_fire;
	assign walk_end = (cur_q >= NIL) || (steps_q >= NIL);
	assign hit = (krd == key_q);
	// The result leaves the walker once the output register is free.
	assign done_fire = (state_q == ST_DONE) && (!ovalid_q || out_ready);

	assign q_ready = (state_q == ST_IDLE);
	assign raddr = cur_q[AW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (q_valid && q_ready) state_d = ST_HEAD;
			ST_HEAD: begin
				if (kind_q == REQ_INSERT && used_q >= NIL) state_d = ST_DONE;
				else state_d = ST_READ;
			end
			ST_READ: state_d = walk_end ? (kind_q == REQ_SEARCH ? ST_DONE : ST_LINK)
				: ST_CHECK;
			ST_CHECK: begin
				if (kind_q == REQ_SEARCH) state_d = hit ? ST_DONE : ST_READ;
				else state_d = (krd < key_q) ? ST_READ : ST_LINK;
			end
			ST_LINK: state_d = ST_DONE;
			ST_DONE: state_d = done_fire ? ST_IDLE : ST_DONE;
			default: state_d = ST_IDLE;
		endcase
	end

	// New node write in ST_LINK at used_q, previous link fixed in ST_DONE.
	always_comb begin
		we = 1'b0;
		kwe = 1'b0;
		waddr = used_q[AW-1:0];
		kwdata = key_q;
		lwdata = cur_q;
		case (state_q)
			ST_LINK: begin
				we = 1'b1;
				kwe = 1'b1;
			end
			ST_DONE: begin
				if (kind_q == REQ_INSERT && !status_q && prev_q < NIL) begin
					we = 1'b1;
					waddr = prev_q[AW-1:0];
					lwdata = used_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < BUCKETS; i++) heads_q[i] <= NIL;
		end else begin
			state_q <= state_d;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			if (done_fire) ovalid_q <= 1'b1;
			if (state_q == ST_LINK) begin
				used_q <= used_q + 1'b1;
				if (prev_q >= NIL) heads_q[bucket_q] <= used_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q <= q_kind;
				key_q <= q_key;
				bucket_q <= q_bucket;
			end
			ST_HEAD: begin
				cur_q <= heads_q[bucket_q];
				prev_q <= NIL;
				steps_q <= '0;
				found_q <= 1'b0;
				status_q <= (kind_q == REQ_INSERT) && (used_q >= NIL);
			end
			ST_CHECK: begin
				if (kind_q == REQ_SEARCH && hit) found_q <= 1'b1;
				else if (kind_q == REQ_SEARCH || krd < key_q) begin
					prev_q <= cur_q;
					cur_q <= lrd;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: ;
		endcase
		if (done_fire) begin
			out_found <= found_q;
			out_key <= found_q ? key_q : '0;
			out_status <= status_q;
		end
	end

	assign out_valid = ovalid_q;

endmodule

/* hdl/chained_hash_table_sorted_unit.sv */
// ----------------------------------------------------------------------------
// chained_hash_table_sorted_unit: sorted separate-chaining hash table
// Inserts and searches 31-bit keys over a fixed node pool.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: tuser is the kind (0 insert,
// 1 search), tdata bits 30:0 the key. Each request gives one result transfer
// on m_axis: tdata bits 30:0 the matched key or zero, tuser bit 0 found and
// bit 1 the pool-full status.
// The front end hashes a key by a reciprocal multiplication and takes a
// new request only once the last one is queued; it queues up to two hashed
// requests. The back end walks the chain through the node RAM, one node
// per pass through ST_READ and ST_CHECK (registered read then compare),
// and the rate is set by the back end.
// Reset empties all buckets and the pool; node RAM contents are not cleared.
// While m_axis is stalled the result is held; the back end may walk the next
// request and then waits before its result, and the front end keeps hashing
// until its queue is full.
// ----------------------------------------------------------------------------
module chained_hash_table_sorted_unit import chts_pkg::*; #(
	parameter int BUCKETS = 10,
	parameter int POOL_NODES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [30:0] key
	input  logic        s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [30:0] key_out
	output logic [1:0]  m_axis_tuser   // [0] found, [1] status
);

	localparam int BW = $clog2(BUCKETS);

	logic             q_valid;
	logic             q_ready;
	logic             q_kind;
	logic [KEY_W-1:0] q_key;
	logic [BW-1:0]    q_bucket;
	logic             found;
	logic [KEY_W-1:0] key_out;
	logic             status;

	chts_front #(.BUCKETS(BUCKETS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_key(s_axis_tdata[30:0]),
		.q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind),
		.q_key(q_key), .q_bucket(q_bucket)
	);

	chts_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_kind(q_kind),
		.q_key(q_key), .q_bucket(q_bucket),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_found(found), .out_key(key_out), .out_status(status)
	);

	assign m_axis_tdata = {1'b0, key_out};
	assign m_axis_tuser = {status, found};

endmodule

/* sim/chained_hash_table_sorted_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_table_sorted_unit_tb: self-checking bench for the hash table
// A directed table of inserts and searches is followed by random requests
// that mostly search, half of them on keys already inserted. Every result
// is checked field by field against a fixed answer or the shadow table.
// ----------------------------------------------------------------------------
module chained_hash_table_sorted_unit_tb import chts_pkg::*; ();

	localparam int BUCKETS = 10;
	localparam int POOL_NODES = 64;
	localparam int EMPTY = POOL_NODES;
	localparam int RANDOM_ITEMS = 1430;
	localparam longint CYCLE_LIMIT = 2000000;
	localparam logic [30:0] KEY_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic        found;
		logic [30:0] key_out;
		logic        status;
	} lookup_result_t;

	typedef struct {
		req_kind_t      kind;
		logic [30:0]    key;
		bit             fixed;
		lookup_result_t answer;
	} request_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	chained_hash_table_sorted_unit #(
		.BUCKETS(BUCKETS),
		.POOL_NODES(POOL_NODES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	// Shadow copy of the table.
	int          chain_head [BUCKETS];
	logic [30:0] node_key [POOL_NODES];
	int          node_next [POOL_NODES];
	int          pool_used;

	request_row_t   rows_in_flight [$];
	lookup_result_t results_due [$];
	int             error_count = 0;
	longint         cycle_count = 0;

	function automatic lookup_result_t table_access(req_kind_t kind, logic [30:0] key);
		lookup_result_t res;
		int b;
		int cur;
		int prev;
		int steps;
		res = '0;
		b = int'(key % BUCKETS);
		cur = chain_head[b];
		steps = 0;
		if (kind == REQ_SEARCH) begin
			while (cur < EMPTY && steps < POOL_NODES) begin
				if (node_key[cur] == key) begin
					res.found = 1'b1;
					res.key_out = key;
					return res;
				end
				cur = node_next[cur];
				steps++;
			end
			return res;
		end
		if (pool_used >= POOL_NODES) begin
			res.status = 1'b1;
			return res;
		end
		prev = EMPTY;
		// New key goes ahead of any equal keys already in the chain.
		while (cur < EMPTY && steps < POOL_NODES && node_key[cur] < key) begin
			prev = cur;
			cur = node_next[cur];
			steps++;
		end
		node_key[pool_used] = key;
		node_next[pool_used] = cur;
		if (prev < EMPTY)
			node_next[prev] = pool_used;
		else
			chain_head[b] = pool_used;
		pool_used++;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		error_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Request side: work out the expected result at each accepted transfer.
	always @(posedge clk) begin
		request_row_t   row;
		lookup_result_t predicted;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			row = rows_in_flight.pop_front();
			predicted = table_access(row.kind, row.key);
			results_due.push_back(row.fixed ? row.answer : predicted);
		end
	end

	// Result side.
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, 32'h0);
			end else begin
				want = results_due.pop_front();
				if (m_axis_tuser[0] !== want.found)
					report_mismatch("found", 32'(m_axis_tuser[0]), 32'(want.found));
				if (m_axis_tdata[30:0] !== want.key_out)
					report_mismatch("key_out", 32'(m_axis_tdata[30:0]), 32'(want.key_out));
				if (m_axis_tuser[1] !== want.status)
					report_mismatch("status", 32'(m_axis_tuser[1]), 32'(want.status));
			end
		end
	end

	// Receiver stalls follow modes of random length.
	initial begin
		int mode;
		int span;
		m_axis_tready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(negedge clk);
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= ($urandom_range(0, 15) != 0);
				endcase
			end
		end
	end

	function automatic request_row_t plain_row(req_kind_t kind, logic [30:0] key);
		request_row_t r;
		r.kind = kind;
		r.key = key;
		r.fixed = 1'b0;
		r.answer = '0;
		return r;
	endfunction

	function automatic request_row_t fixed_row(req_kind_t kind, logic [30:0] key,
			lookup_result_t answer);
		request_row_t r;
		r = plain_row(kind, key);
		r.fixed = 1'b1;
		r.answer = answer;
		return r;
	endfunction

	logic [30:0] keys_inserted [$];
	int          inserts_sent;

	function automatic logic [30:0] pick_key();
		case ($urandom_range(0, 4))
			0: return 31'($urandom_range(0, 99));
			1: return 31'($urandom_range(0, 50) * BUCKETS + 3);
			2: return KEY_MAX - 31'($urandom_range(0, 40));
			default: return 31'($urandom());
		endcase
	endfunction

	function automatic request_row_t random_row();
		logic [30:0] key;
		int          ins_pct;
		ins_pct = (inserts_sent < POOL_NODES) ? 12 : 25;
		if ($urandom_range(0, 99) < ins_pct) begin
			if (keys_inserted.size() > 0 && $urandom_range(0, 4) == 0)
				key = keys_inserted[$urandom_range(0, keys_inserted.size() - 1)];
			else
				key = pick_key();
			keys_inserted.push_back(key);
			inserts_sent++;
			return plain_row(REQ_INSERT, key);
		end
		if (keys_inserted.size() > 0 && $urandom_range(0, 1) == 0)
			key = keys_inserted[$urandom_range(0, keys_inserted.size() - 1)];
		else
			key = pick_key();
		return plain_row(REQ_SEARCH, key);
	endfunction

	task automatic send_row(request_row_t row);
		rows_in_flight.push_back(row);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, row.key};
		s_axis_tuser <= row.kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
	endtask

	request_row_t directed [$];

	initial begin
		lookup_result_t miss;
		lookup_result_t hit_max;
		lookup_result_t hit_zero;
		int burst;
		int gap;
		int sent;
		miss = '0;
		hit_max = '0;
		hit_max.found = 1'b1;
		hit_max.key_out = KEY_MAX;
		hit_zero = '0;
		hit_zero.found = 1'b1;
		inserts_sent = 0;
		pool_used = 0;
		for (int i = 0; i < BUCKETS; i++) chain_head[i] = EMPTY;
		for (int i = 0; i < POOL_NODES; i++) begin
			node_key[i] = '0;
			node_next[i] = 0;
		end
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;

		// Empty table, extremes, one sorted chain with a duplicate.
		directed.push_back(fixed_row(REQ_SEARCH, 31'd0, miss));
		directed.push_back(fixed_row(REQ_SEARCH, KEY_MAX, miss));
		directed.push_back(fixed_row(REQ_INSERT, KEY_MAX, miss));
		directed.push_back(fixed_row(REQ_SEARCH, KEY_MAX, hit_max));
		directed.push_back(fixed_row(REQ_INSERT, 31'd0, miss));
		directed.push_back(fixed_row(REQ_SEARCH, 31'd0, hit_zero));
		directed.push_back(plain_row(REQ_INSERT, 31'd30));
		directed.push_back(plain_row(REQ_INSERT, 31'd10));
		directed.push_back(plain_row(REQ_INSERT, 31'd50));
		directed.push_back(plain_row(REQ_INSERT, 31'd20));
		directed.push_back(plain_row(REQ_INSERT, 31'd20));
		directed.push_back(plain_row(REQ_SEARCH, 31'd10));
		directed.push_back(plain_row(REQ_SEARCH, 31'd20));
		directed.push_back(plain_row(REQ_SEARCH, 31'd50));
		directed.push_back(fixed_row(REQ_SEARCH, 31'd40, miss));
		directed.push_back(fixed_row(REQ_SEARCH, 31'd11, miss));
		directed.push_back(plain_row(REQ_INSERT, 31'h5555_5555));
		directed.push_back(plain_row(REQ_SEARCH, 31'h5555_5555));
		directed.push_back(plain_row(REQ_SEARCH, 31'h2AAA_AAAA));
		inserts_sent = 8;
		keys_inserted = '{KEY_MAX, 31'd0, 31'd30, 31'd10, 31'd50, 31'd20,
			31'h5555_5555};

		@(posedge arst_n);
		@(negedge clk);
		foreach (directed[i]) send_row(directed[i]);

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
				send_row(random_row());
				sent++;
			end
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;

		while (results_due.size() > 0 || rows_in_flight.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
